// ===== sv/cnv3_pkg.sv =====
`default_nettype none
package cnv3_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_CHANNELS  = 3;
    localparam int SW            = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR  = 3'd4;

    localparam logic [1:0] MODE_BLUR    = 2'd0;
    localparam logic [1:0] MODE_LAPLACE = 2'd1;
    localparam logic [1:0] MODE_SHARPEN = 2'd2;

    localparam int RECIP_SHIFT = 24;

    // ceil(2^24 / d) for d in 1..6 or 9, exact for dividends below 2^20
    function automatic logic [24:0] recip(input logic [3:0] d);
        logic [24:0] m;
        case (d)
            4'd1:    m = 25'd16777216;
            4'd2:    m = 25'd8388608;
            4'd3:    m = 25'd5592406;
            4'd4:    m = 25'd4194304;
            4'd5:    m = 25'd3355444;
            4'd6:    m = 25'd2796203;
            4'd9:    m = 25'd1864136;
            default: m = 25'd16777216;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== sv/cnv3_in_if.sv =====
`default_nettype none
interface cnv3_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] sample_a;
    logic [15:0] sample_b;
    logic [15:0] sample_c;
    modport source (output valid, func, sample_a, sample_b, sample_c, input ready);
    modport sink (input valid, func, sample_a, sample_b, sample_c, output ready);
endinterface
`default_nettype wire

// ===== sv/cnv3_out_if.sv =====
`default_nettype none
interface cnv3_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_a;
    logic [15:0] out_b;
    logic [15:0] out_c;
    logic        end_of_frame;
    modport source (output valid, out_a, out_b, out_c, end_of_frame, input ready);
    modport sink (input valid, out_a, out_b, out_c, end_of_frame, output ready);
endinterface
`default_nettype wire

// ===== sv/cnv3_ram.sv =====
`default_nettype none
module cnv3_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== sv/conv3x3_normalized_filter_unit.sv =====
`default_nettype none
// 3x3 image filter (box blur, Laplace, sharpen) over a raster stream of 1..3
// channel pixels. Takes one word per cycle and gives one result per cycle once
// full, unless the output stalls; a result leaves five register stages after its
// last input enters (line store read, window shift, kernel sum, reciprocal
// multiply, clamp). Results lag the input by one row plus one pixel; after the
// last pixel, flush words (or pixels, then ignored) drain the rest of the frame.
// Line stores need no clearing after reset. Write configuration only while idle.
module conv3x3_normalized_filter_unit #(
    parameter int MAX_WIDTH = cnv3_pkg::DEF_MAX_WIDTH,
    parameter int CHANNELS  = cnv3_pkg::DEF_CHANNELS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    cnv3_in_if.sink                              i_in,
    cnv3_out_if.source                           o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [cnv3_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [cnv3_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cnv3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > 11) ? CW + 1 : 11;
    localparam int PW = SW * CHANNELS;

    // configuration
    logic [10:0] r_width;
    logic [15:0] r_height;
    logic [1:0]  r_mode;
    logic [15:0] r_max;
    logic        r_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd1024;
            r_height <= 16'd1;
            r_mode   <= MODE_BLUR;
            r_max    <= 16'd255;
            r_color  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_width  <= i_cfg_data[10:0];
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                CFG_MAX:    r_max    <= i_cfg_data;
                CFG_COLOR:  r_color  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [WW-1:0] w_eff;
    logic [15:0]   h_eff;
    always_comb begin
        w_eff = WW'(r_width);
        if (w_eff == '0) w_eff = WW'(1);
        if (w_eff > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
        h_eff = (r_height == 16'd0) ? 16'd1 : r_height;
    end

    // pipeline enable: everything moves when the output register is free
    logic en;
    assign en = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    // input and output position counters
    logic [CW-1:0] r_in_col, r_out_col, n_in_col, n_out_col;
    logic [15:0]   r_in_row, r_out_row, n_in_row, n_out_row;
    logic          draining, keep, emit, in_last, out_last_col, out_last_row, eof;
    logic [8:0]    mask;

    assign draining     = r_in_row >= h_eff;
    assign keep         = i_in.valid && en && (draining || !i_in.func);
    assign emit         = (r_in_row >= 16'd2) || (r_in_row == 16'd1 && r_in_col != '0);
    assign in_last      = (WW'(r_in_col) + WW'(1)) >= w_eff;
    assign out_last_col = (WW'(r_out_col) + WW'(1)) >= w_eff;
    assign out_last_row = ({1'b0, r_out_row} + 17'd1) >= {1'b0, h_eff};
    assign eof          = out_last_row && out_last_col;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            mask[i] = 1'b1;
            if (i / 3 == 0 && r_out_row == 16'd0) mask[i] = 1'b0;
            if (i / 3 == 2 && out_last_row) mask[i] = 1'b0;
            if (i % 3 == 0 && r_out_col == '0) mask[i] = 1'b0;
            if (i % 3 == 2 && out_last_col) mask[i] = 1'b0;
        end
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (keep) begin
            if (in_last) begin
                n_in_col = '0;
                if (r_in_row != 16'hFFFF) n_in_row = r_in_row + 16'd1;
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
            if (emit) begin
                if (eof) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (out_last_col) begin
                    n_out_col = '0;
                    if (r_out_row != 16'hFFFF) n_out_row = r_out_row + 16'd1;
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    logic [PW-1:0] pix;
    always_comb begin
        for (int k = 0; k < CHANNELS; k++) begin
            case (k)
                0:       pix[k*SW +: SW] = i_in.sample_a;
                1:       pix[k*SW +: SW] = i_in.sample_b;
                default: pix[k*SW +: SW] = i_in.sample_c;
            endcase
        end
    end

    // stage 1: line store read data back, write-back, window shift
    logic          r_s1_v, r_s1_drain, r_s1_emit, r_s1_eof, r_byp_sel;
    logic [PW-1:0] r_s1_pix;
    logic [CW-1:0] r_s1_col;
    logic [8:0]    r_s1_mask;
    logic [2*PW-1:0] r_byp, ram_q, s1_word, wr_word;
    logic          wr_en, byp_hit;

    assign s1_word = r_byp_sel ? r_byp : ram_q;
    assign wr_word = {s1_word[PW-1:0], r_s1_pix};
    assign wr_en   = en && r_s1_v && !r_s1_drain;
    // a write to the column read in the same cycle bypasses the memory
    assign byp_hit = keep && wr_en && (r_s1_col == r_in_col);

    cnv3_ram #(.WIDTH(2 * PW), .DEPTH(MAX_WIDTH)) u_lines (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_col),
        .i_wdata (wr_word),
        .i_re    (keep),
        .i_raddr (r_in_col),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_byp_sel <= 1'b0;
        end else if (en) begin
            r_s1_v    <= keep;
            r_byp_sel <= byp_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_drain <= draining;
            r_s1_pix   <= pix;
            r_s1_col   <= r_in_col;
            r_s1_emit  <= emit;
            r_s1_mask  <= mask;
            r_s1_eof   <= eof;
            r_byp      <= wr_word;
        end
    end

    logic [PW-1:0] r_win [9];
    logic          r_s2_v, r_s2_eof;
    logic [8:0]    r_s2_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) r_win[i] <= '0;
        end else if (en && r_s1_v) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]     <= r_win[r*3+1];
                r_win[r*3 + 1] <= r_win[r*3+2];
            end
            r_win[2] <= s1_word[2*PW-1:PW];
            r_win[5] <= s1_word[PW-1:0];
            r_win[8] <= r_s1_drain ? '0 : r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_s1_v && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_mask <= r_s1_mask;
            r_s2_eof  <= r_s1_eof;
        end
    end

    // stage 2: kernel sums per channel
    logic signed [20:0] s2_sum [3];
    logic [3:0]         s2_div;

    for (genvar k = 0; k < 3; k++) begin : g_sum
        if (k < CHANNELS) begin : g_on
            logic [15:0] v [9];
            logic [19:0] blur;
            logic [17:0] nb;
            logic [18:0] ctrm;
            always_comb begin
                for (int i = 0; i < 9; i++) begin
                    v[i] = r_s2_mask[i] ? r_win[i][k*SW +: SW] : 16'd0;
                end
                blur = '0;
                for (int i = 0; i < 9; i++) blur = blur + 20'(v[i]);
                nb   = 18'(v[1]) + 18'(v[3]) + 18'(v[5]) + 18'(v[7]);
                ctrm = (r_mode == MODE_SHARPEN) ? 19'(v[4]) * 19'd5 : 19'(v[4]) * 19'd4;
                if (r_mode == MODE_LAPLACE || r_mode == MODE_SHARPEN) begin
                    s2_sum[k] = signed'({2'b00, ctrm}) - signed'({3'b000, nb});
                end else begin
                    s2_sum[k] = signed'({1'b0, blur});
                end
            end
        end else begin : g_off
            assign s2_sum[k] = '0;
        end
    end

    always_comb begin
        case (r_mode)
            MODE_LAPLACE: s2_div = 4'd4;
            MODE_SHARPEN: s2_div = 4'd5;
            default:      s2_div = 4'($countones(r_s2_mask));
        endcase
    end

    logic               r_s3_v, r_s3_eof;
    logic signed [20:0] r_s3_sum [3];
    logic [3:0]         r_s3_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_eof <= r_s2_eof;
            r_s3_div <= s2_div;
            for (int k = 0; k < 3; k++) r_s3_sum[k] <= s2_sum[k];
        end
    end

    // stage 3: divide by reciprocal multiply
    logic        r_s4_v, r_s4_eof;
    logic [19:0] r_s4_q [3];
    logic        r_s4_pos [3];
    logic [24:0] s3_m;
    logic [44:0] s3_prod [3];

    assign s3_m = recip(r_s3_div);
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s3_prod[k] = 45'(r_s3_sum[k][19:0]) * 45'(s3_m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (en) begin
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_eof <= r_s3_eof;
            for (int k = 0; k < 3; k++) begin
                r_s4_q[k]   <= s3_prod[k][RECIP_SHIFT +: 20];
                r_s4_pos[k] <= r_s3_sum[k] > 21'sd0;
            end
        end
    end

    // stage 4: clamp and channel gating
    logic [15:0] s4_out [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!r_s4_pos[k] || (k > 0 && !r_color)) begin
                s4_out[k] = 16'd0;
            end else if (r_s4_q[k] > 20'(r_max)) begin
                s4_out[k] = r_max;
            end else begin
                s4_out[k] = r_s4_q[k][15:0];
            end
        end
    end

    logic        r_o_valid, r_o_eof;
    logic [15:0] r_o_a, r_o_b, r_o_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_a   <= s4_out[0];
            r_o_b   <= s4_out[1];
            r_o_c   <= s4_out[2];
            r_o_eof <= r_s4_eof;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.out_a        = r_o_a;
    assign o_out.out_b        = r_o_b;
    assign o_out.out_c        = r_o_c;
    assign o_out.end_of_frame = r_o_eof;

`ifndef ASSERT_OFF
    a_grey_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !r_color |-> o_out.out_b == 16'd0 && o_out.out_c == 16'd0)
        else $error("channel b or c nonzero in grey mode");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.out_a <= r_max)
        else $error("result above clamp limit");

    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp_sel |-> r_s1_v)
        else $error("line store bypass without a word in stage one");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_in_col) && $stable(r_out_row))
        else $error("counters moved during a stall");
`endif
endmodule
`default_nettype wire
